FILE: hdl/crc16fr_pkg.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver package
// Shared widths, register indexes, parser phases and the frame descriptor.
// ----------------------------------------------------------------------------
package crc16fr_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 64;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 7;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned CRC_W  = 16;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
	localparam logic [LEN_W-1:0]  CAPACITY_RST    = 7'd64;

	typedef enum logic [1:0] {
		REG_SYNC_FIRST  = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_CAPACITY    = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_HUNT_A = 3'd0,
		PH_HUNT_B = 3'd1,
		PH_TYPE   = 3'd2,
		PH_LEN    = 3'd3,
		PH_DATA   = 3'd4,
		PH_CRC_LO = 3'd5,
		PH_CRC_HI = 3'd6
	} phase_t;

	// One good frame, handed from the parser to the emitter.
	typedef struct packed {
		logic [BYTE_W-1:0] frame_type;
		logic [LEN_W-1:0]  length;
		logic              withheld;
		logic              bank;
	} desc_t;

endpackage

FILE: hdl/crc16fr_ram.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver payload buffer
// Two banks of payload bytes, one write port, one registered read port.
// ----------------------------------------------------------------------------
module crc16fr_ram
	import crc16fr_pkg::*;
#(
	parameter int unsigned AW = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW:0]       waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW:0]       raddr,
	output logic [BYTE_W-1:0] rdata
);

	localparam int unsigned DEPTH = 2 << AW;

	logic [BYTE_W-1:0] mem_q [0:DEPTH-1];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/crc16fr_front.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver parser
// Hunts for the sync pair, takes type and length, stores the payload and
// checks the trailing CRC; a good frame leaves as a descriptor.
// ----------------------------------------------------------------------------
module crc16fr_front
	import crc16fr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int unsigned AW          = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] sync_first,
	input  logic [BYTE_W-1:0] sync_second,
	input  logic [LEN_W-1:0]  capacity,
	output logic              wr_en,
	output logic [AW:0]       wr_addr,
	output logic [BYTE_W-1:0] wr_data,
	output logic              desc_push,
	output desc_t             desc
);

	localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_PAYLOAD);

	phase_t             phase_q, phase_d;
	logic               bank_q;
	logic [BYTE_W-1:0]  type_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   fill_q;
	logic [LEN_W-1:0]   fill_inc;
	logic [CRC_W-1:0]   crc_q;
	logic [BYTE_W-1:0]  crc_lo_q;
	logic               crc_ok;

	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] c,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((r & CRC_MSB) != '0) begin
				r = (r << 1) ^ CRC_POLY;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	assign fill_inc = fill_q + LEN_W'(1);
	assign crc_ok   = ({rx_byte, crc_lo_q} == crc_q);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			case (phase_q)
				PH_HUNT_A: begin
					if (rx_byte == sync_first) phase_d = PH_HUNT_B;
				end
				PH_HUNT_B: begin
					if (rx_byte == sync_second) begin
						phase_d = PH_TYPE;
					end else if (rx_byte != sync_first) begin
						phase_d = PH_HUNT_A;
					end
				end
				PH_TYPE: phase_d = PH_LEN;
				PH_LEN: begin
					if (rx_byte > MAX_LEN_B) begin
						phase_d = PH_HUNT_A;
					end else if (rx_byte == '0) begin
						phase_d = PH_CRC_LO;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					if (fill_inc >= len_q) phase_d = PH_CRC_LO;
				end
				PH_CRC_LO: phase_d = PH_CRC_HI;
				PH_CRC_HI: phase_d = PH_HUNT_A;
				default:   phase_d = PH_HUNT_A;
			endcase
		end
	end

	// Outputs
	always_comb begin
		wr_en     = 1'b0;
		desc_push = 1'b0;
		case (phase_q)
			PH_DATA:   wr_en     = accept;
			PH_CRC_HI: desc_push = accept && crc_ok;
			default: begin
				wr_en     = 1'b0;
				desc_push = 1'b0;
			end
		endcase
	end

	assign wr_addr         = {bank_q, fill_q[AW-1:0]};
	assign wr_data         = rx_byte;
	assign desc.frame_type = type_q;
	assign desc.length     = len_q;
	assign desc.withheld   = (len_q == '0) || (len_q > capacity);
	assign desc.bank       = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT_A;
			bank_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			// flip to the other bank once a good frame owns this one
			if (desc_push) bank_q <= ~bank_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				PH_TYPE: begin
					type_q <= rx_byte;
					crc_q  <= crc_feed(CRC_INIT, rx_byte);
				end
				PH_LEN: begin
					if (rx_byte <= MAX_LEN_B) begin
						len_q  <= rx_byte[LEN_W-1:0];
						crc_q  <= crc_feed(crc_q, rx_byte);
						fill_q <= '0;
					end
				end
				PH_DATA: begin
					crc_q  <= crc_feed(crc_q, rx_byte);
					fill_q <= fill_inc;
				end
				PH_CRC_LO: crc_lo_q <= rx_byte;
				default: begin
					crc_lo_q <= crc_lo_q;
				end
			endcase
		end
	end

endmodule

FILE: hdl/crc16fr_queue.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver descriptor queue
// Two-entry queue of good frames between parser and emitter.
// ----------------------------------------------------------------------------
module crc16fr_queue
	import crc16fr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t din,
	input  logic  pop,
	output desc_t head,
	output logic  head_valid,
	output logic  full
);

	desc_t      entry_q [0:1];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign head       = entry_q[rptr_q];
	assign head_valid = (count_q != 2'd0);
	assign full       = (count_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wptr_q] <= din;
	end

endmodule

FILE: hdl/crc16fr_back.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver emitter
// Walks the head frame byte by byte into a one-entry result register.
// ----------------------------------------------------------------------------
module crc16fr_back
	import crc16fr_pkg::*;
#(
	parameter int unsigned AW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  desc_t             head,
	input  logic              head_valid,
	output logic              desc_pop,
	output logic              rd_en,
	output logic [AW:0]       rd_addr,
	input  logic [BYTE_W-1:0] rd_data,
	input  logic              pop,
	output logic              empty,
	output logic [BYTE_W-1:0] frame_type,
	output logic [LEN_W-1:0]  frame_length,
	output logic [BYTE_W-1:0] payload_byte,
	output logic [IDX_W-1:0]  byte_index,
	output logic              data_valid,
	output logic              last
);

	logic              out_v_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              load;
	logic              last_now;
	logic [BYTE_W-1:0] type_q;
	logic [LEN_W-1:0]  len_q;
	logic [IDX_W-1:0]  idx_q;
	logic              valid_q;
	logic              last_q;

	// refill the result register when it is empty or being drained
	assign load     = head_valid && (!out_v_q || pop);
	assign last_now = head.withheld || ((LEN_W'(cnt_q) + LEN_W'(1)) == head.length);
	assign desc_pop = load && last_now;
	assign rd_en    = load && !head.withheld;
	assign rd_addr  = {head.bank, cnt_q[AW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				cnt_q   <= last_now ? '0 : cnt_q + IDX_W'(1);
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			type_q  <= head.frame_type;
			len_q   <= head.length;
			idx_q   <= head.withheld ? '0 : cnt_q;
			valid_q <= !head.withheld;
			last_q  <= last_now;
		end
	end

	assign empty        = !out_v_q;
	assign frame_type   = type_q;
	assign frame_length = len_q;
	assign payload_byte = valid_q ? rd_data : '0;
	assign byte_index   = idx_q;
	assign data_valid   = valid_q;
	assign last         = last_q;

endmodule

FILE: hdl/crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver
// Sync/type/length framed byte parser with CRC-16/CCITT-FALSE check.
//
//   channel   handshake        payload
//   -------   --------------   ----------------------------------------------
//   input     push / full      rx_byte
//   result    pop / empty      frame_type frame_length payload_byte
//                              byte_index data_valid last
//   config    wr_en            wr_index wr_data
//
// The parser takes one byte per cycle while full is low; the emitter gives one
// result per cycle from the payload buffer while pop is held and a frame is
// queued. A frame of n payload bytes is n + 6 input bytes.
// Two good frames may be held (queued or being emitted); while both
// buffer banks are held, full stays high. No clearing pass after reset.
// ----------------------------------------------------------------------------
module crc16_frame_receiver
	import crc16fr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] frame_type,
	output logic [LEN_W-1:0]  frame_length,
	output logic [BYTE_W-1:0] payload_byte,
	output logic [IDX_W-1:0]  byte_index,
	output logic              data_valid,
	output logic              last,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [BYTE_W-1:0] wr_data
);

	localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic [LEN_W-1:0]  capacity_q;

	logic              accept;
	logic              ram_we;
	logic [AW:0]       ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW:0]       ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic              desc_push;
	logic              desc_pop;
	desc_t             desc_in;
	desc_t             desc_head;
	logic              head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			capacity_q    <= CAPACITY_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SYNC_FIRST:  sync_first_q  <= wr_data;
				REG_SYNC_SECOND: sync_second_q <= wr_data;
				REG_CAPACITY:    capacity_q    <= wr_data[LEN_W-1:0];
				default:         capacity_q    <= capacity_q;
			endcase
		end
	end

	assign accept = push && !full;

	crc16fr_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.capacity    (capacity_q),
		.wr_en       (ram_we),
		.wr_addr     (ram_waddr),
		.wr_data     (ram_wdata),
		.desc_push   (desc_push),
		.desc        (desc_in)
	);

	crc16fr_ram #(
		.AW (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	crc16fr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (desc_push),
		.din        (desc_in),
		.pop        (desc_pop),
		.head       (desc_head),
		.head_valid (head_valid),
		.full       (full)
	);

	crc16fr_back #(
		.AW (AW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (desc_head),
		.head_valid   (head_valid),
		.desc_pop     (desc_pop),
		.rd_en        (ram_re),
		.rd_addr      (ram_raddr),
		.rd_data      (ram_rdata),
		.pop          (pop && !empty),
		.empty        (empty),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.data_valid   (data_valid),
		.last         (last)
	);

endmodule

FILE: tb/crc16_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// CRC-16 frame receiver testbench
// Feeds framed byte streams through the queue-style input and checks every
// result transfer against a byte-level parser model kept in the bench. Covers
// marker hunting, length and capacity limits, CRC failures, register settings
// and a long result stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crc16fr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int ROUND_BYTES = 8;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] ftype;
		logic [LEN_W-1:0]  flen;
		logic [BYTE_W-1:0] pbyte;
		logic [IDX_W-1:0]  idx;
		logic              valid;
		logic              fin;
	} rx_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push;
	logic              full;
	logic [BYTE_W-1:0] rx_byte;
	logic              empty;
	logic              pop;
	logic [BYTE_W-1:0] frame_type;
	logic [LEN_W-1:0]  frame_length;
	logic [BYTE_W-1:0] payload_byte;
	logic [IDX_W-1:0]  byte_index;
	logic              data_valid;
	logic              last;
	logic              wr_en;
	logic [1:0]        wr_index;
	logic [BYTE_W-1:0] wr_data;

	// register copies
	logic [BYTE_W-1:0] cfg_sync_first = SYNC_FIRST_RST;
	logic [BYTE_W-1:0] cfg_sync_second = SYNC_SECOND_RST;
	logic [LEN_W-1:0]  cfg_capacity = CAPACITY_RST;

	// parser model state
	phase_t            rx_phase = PH_HUNT_A;
	logic [BYTE_W-1:0] rx_type = '0;
	logic [LEN_W-1:0]  rx_len = '0;
	int                rx_fill = 0;
	logic [CRC_W-1:0]  rx_crc = CRC_INIT;
	logic [CRC_W-1:0]  rx_crc_got = '0;
	logic [BYTE_W-1:0] rx_store [MAX_PAYLOAD_DEF];

	rx_result_t        pending_results [$];
	int                errors = 0;
	int                cycle_count = 0;
	int                bytes_sent = 0;
	bit                sender_gaps = 1'b1;
	bit                drain_gaps = 1'b1;
	bit                drain_hold_req = 1'b0;
	int                drain_hold_len = 0;

	crc16_frame_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.data_valid   (data_valid),
		.last         (last),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [CRC_W-1:0] crc_ccitt_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != '0)
				c = (c << 1) ^ CRC_POLY;
			else
				c = c << 1;
		end
		return c;
	endfunction

	// Advance the parser model by one accepted byte and queue what it yields.
	function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b);
		rx_result_t r;
		case (rx_phase)
			PH_HUNT_A: begin
				if (b == cfg_sync_first)
					rx_phase = PH_HUNT_B;
			end
			PH_HUNT_B: begin
				// second marker wins when both registers match
				if (b == cfg_sync_second)
					rx_phase = PH_TYPE;
				else if (b != cfg_sync_first)
					rx_phase = PH_HUNT_A;
			end
			PH_TYPE: begin
				rx_type = b;
				rx_crc = crc_ccitt_byte(CRC_INIT, b);
				rx_phase = PH_LEN;
			end
			PH_LEN: begin
				if (b > MAX_PAYLOAD_DEF) begin
					rx_phase = PH_HUNT_A;
				end else begin
					rx_len = b[LEN_W-1:0];
					rx_crc = crc_ccitt_byte(rx_crc, b);
					rx_fill = 0;
					rx_phase = (b == '0) ? PH_CRC_LO : PH_DATA;
				end
			end
			PH_DATA: begin
				if (rx_fill < MAX_PAYLOAD_DEF)
					rx_store[rx_fill] = b;
				rx_crc = crc_ccitt_byte(rx_crc, b);
				rx_fill++;
				if (rx_fill >= rx_len)
					rx_phase = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				rx_crc_got = {8'h00, b};
				rx_phase = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				rx_crc_got[15:8] = b;
				rx_phase = PH_HUNT_A;
				if (rx_crc_got == rx_crc) begin
					if (rx_len == '0 || rx_len > cfg_capacity || rx_len > MAX_PAYLOAD_DEF) begin
						// empty or withheld payload: one result, no data
						r = '{ftype: rx_type, flen: rx_len, pbyte: '0, idx: '0,
							valid: 1'b0, fin: 1'b1};
						pending_results.push_back(r);
					end else begin
						for (int i = 0; i < rx_len; i++) begin
							r = '{ftype: rx_type, flen: rx_len, pbyte: rx_store[i],
								idx: i[IDX_W-1:0], valid: 1'b1, fin: (i == rx_len - 1)};
							pending_results.push_back(r);
						end
					end
				end
			end
			default: begin
				rx_phase = PH_HUNT_A;
			end
		endcase
	endfunction

	function automatic int pick_gap(input bit enable);
		int r;
		if (!enable)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
		end
	endfunction

	always @(posedge clk) begin : result_check
		rx_result_t want;
		if (arst_n && pop && empty === 1'b0) begin
			if (pending_results.size() == 0) begin
				errors++;
				$error("result transfer with no frame result expected");
			end else begin
				want = pending_results.pop_front();
				compare_field("frame_type", want.ftype, frame_type);
				compare_field("frame_length", BYTE_W'(want.flen), BYTE_W'(frame_length));
				compare_field("payload_byte", want.pbyte, payload_byte);
				compare_field("byte_index", BYTE_W'(want.idx), BYTE_W'(byte_index));
				compare_field("data_valid", BYTE_W'(want.valid), BYTE_W'(data_valid));
				compare_field("last", BYTE_W'(want.fin), BYTE_W'(last));
			end
		end
	end

	// Result side: random pop gaps, plus a long hold-off on request.
	initial begin : result_drain
		int g;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (drain_hold_req) begin
				g = drain_hold_len;
				drain_hold_req = 1'b0;
			end else begin
				g = pick_gap(drain_gaps);
			end
			if (g > 0) begin
				pop <= 1'b0;
				repeat (g) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0 && !drain_hold_req);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int g;
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full !== 1'b0);
		parse_rx_byte(b);
		bytes_sent++;
		g = pick_gap(sender_gaps);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// fill below zero: random payload bytes
	task automatic send_frame(input logic [BYTE_W-1:0] ftype, input logic [BYTE_W-1:0] flen,
			input int fill, input bit corrupt);
		logic [CRC_W-1:0]  crc;
		logic [BYTE_W-1:0] pb;
		send_byte(cfg_sync_first);
		send_byte(cfg_sync_second);
		send_byte(ftype);
		send_byte(flen);
		if (flen > MAX_PAYLOAD_DEF)
			return;
		crc = crc_ccitt_byte(crc_ccitt_byte(CRC_INIT, ftype), flen);
		for (int i = 0; i < flen; i++) begin
			pb = (fill < 0) ? BYTE_W'($urandom_range(0, 255)) : fill[BYTE_W-1:0];
			crc = crc_ccitt_byte(crc, pb);
			send_byte(pb);
		end
		if (corrupt)
			crc ^= 16'h0001 << $urandom_range(0, 15);
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
	endtask

	// Walk the parser back to the marker hunt with a byte that cannot start a frame.
	task automatic flush_parser();
		logic [BYTE_W-1:0] filler;
		filler = 8'hFF;
		while (filler == cfg_sync_first || filler == cfg_sync_second)
			filler--;
		while (rx_phase != PH_HUNT_A)
			send_byte(filler);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			REG_SYNC_FIRST:  cfg_sync_first = data;
			REG_SYNC_SECOND: cfg_sync_second = data;
			REG_CAPACITY:    cfg_capacity = data[LEN_W-1:0];
			default: ; // no such register: write is dropped
		endcase
	endtask

	task automatic apply_config(input logic [BYTE_W-1:0] sync_a, input logic [BYTE_W-1:0] sync_b,
			input logic [BYTE_W-1:0] cap);
		flush_parser();
		wait_drained();
		write_reg(REG_UNUSED, BYTE_W'($urandom_range(0, 255)));
		write_reg(REG_SYNC_FIRST, sync_a);
		write_reg(REG_SYNC_SECOND, sync_b);
		write_reg(REG_CAPACITY, cap);
		wr_en <= 1'b0;
	endtask

	task automatic test_basic_frames();
		send_frame(8'hFF, 8'd64, 255, 1'b0);
		send_frame(8'h81, 8'd0, -1, 1'b0);
		send_frame(8'h3C, 8'd3, -1, 1'b0);
	endtask

	task automatic test_sync_hunt();
		// repeated first marker keeps the hunt armed
		send_byte(cfg_sync_first);
		send_byte(cfg_sync_first);
		send_frame(8'h11, 8'd1, -1, 1'b0);
		// broken marker drops back to hunting
		send_byte(cfg_sync_first);
		send_byte(8'h12);
		send_byte(cfg_sync_second);
		send_frame(8'h13, 8'd1, -1, 1'b0);
	endtask

	task automatic test_bad_frames();
		send_frame(8'h22, 8'd2, -1, 1'b1);
		send_frame(8'h23, 8'd0, -1, 1'b1);
		send_frame(8'h24, 8'd65, -1, 1'b0);
		send_frame(8'h25, 8'd255, -1, 1'b0);
		send_frame(8'h26, 8'd1, -1, 1'b0);
	endtask

	task automatic test_capacity();
		// top bit of the write data falls outside the register
		apply_config(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h82);
		send_frame(8'h31, 8'd2, -1, 1'b0);
		send_frame(8'h32, 8'd3, -1, 1'b0);
		send_frame(8'h33, 8'd0, -1, 1'b0);
		apply_config(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd0);
		send_frame(8'h34, 8'd1, -1, 1'b0);
		apply_config(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd127);
		send_frame(8'h36, 8'd4, -1, 1'b0);
		apply_config(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd65);
		send_frame(8'h37, 8'd4, -1, 1'b0);
	endtask

	task automatic test_sync_registers();
		apply_config(8'h00, 8'hFF, 8'd64);
		send_byte(8'h00);
		send_frame(8'h41, 8'd2, -1, 1'b0);
		apply_config(8'hFF, 8'h00, 8'd64);
		send_frame(8'h42, 8'd2, -1, 1'b0);
		// identical markers: the second byte completes the marker
		apply_config(8'h3C, 8'h3C, 8'd64);
		send_frame(8'h43, 8'd1, -1, 1'b0);
		send_byte(8'h3C);
		send_frame(8'h3C, 8'd2, -1, 1'b0);
		apply_config(SYNC_FIRST_RST, SYNC_SECOND_RST, CAPACITY_RST);
	endtask

	task automatic test_backpressure();
		// stall the result side long enough for both buffers to fill and full to rise
		sender_gaps = 1'b0;
		drain_hold_len = 300;
		drain_hold_req = 1'b1;
		repeat (3)
			send_frame(BYTE_W'($urandom_range(0, 255)), 8'd2, -1, 1'b0);
		sender_gaps = 1'b1;
		// hold the input until every result has been transferred
		wait_drained();
		send_frame(8'h51, 8'd2, -1, 1'b0);
	endtask

	task automatic test_random_traffic();
		int start;
		int kind;
		logic [BYTE_W-1:0] sa;
		logic [BYTE_W-1:0] sb;
		logic [BYTE_W-1:0] flen;
		for (int round = 0; round < 3; round++) begin
			sa = BYTE_W'($urandom_range(0, 255));
			sb = ($urandom_range(0, 3) == 0) ? sa : BYTE_W'($urandom_range(0, 255));
			case (round)
				0: apply_config(SYNC_FIRST_RST, SYNC_SECOND_RST, CAPACITY_RST);
				1: apply_config(sa, sb, BYTE_W'($urandom_range(1, 64)));
				default: apply_config(sa, sb, BYTE_W'($urandom_range(64, 255)));
			endcase
			start = bytes_sent;
			while (bytes_sent - start < ROUND_BYTES) begin
				sender_gaps = ($urandom_range(0, 4) != 0);
				drain_gaps = ($urandom_range(0, 4) != 0);
				kind = $urandom_range(0, 99);
				flen = ($urandom_range(0, 9) < 8) ? BYTE_W'($urandom_range(0, 8))
					: BYTE_W'($urandom_range(9, 32));
				if (kind < 68) begin
					send_frame(BYTE_W'($urandom_range(0, 255)), flen, -1, 1'b0);
				end else if (kind < 78) begin
					send_frame(BYTE_W'($urandom_range(0, 255)), flen, -1, 1'b1);
				end else if (kind < 84) begin
					send_frame(BYTE_W'($urandom_range(0, 255)),
						BYTE_W'($urandom_range(65, 255)), -1, 1'b0);
				end else if (kind < 94) begin
					repeat ($urandom_range(1, 6))
						send_byte(BYTE_W'($urandom_range(0, 255)));
				end else begin
					send_byte(cfg_sync_first);
					send_byte(BYTE_W'($urandom_range(0, 255)));
				end
			end
		end
		sender_gaps = 1'b1;
		drain_gaps = 1'b1;
	endtask

	initial begin
		push = 1'b0;
		rx_byte = '0;
		wr_en = 1'b0;
		wr_index = REG_SYNC_FIRST;
		wr_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_sync_hunt();
		test_bad_frames();
		test_capacity();
		test_sync_registers();
		test_backpressure();
		test_random_traffic();

		wait_drained();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
